// File: design/kvrt_pkg.sv
`timescale 1ns / 1ps

package kvrt_pkg;

    localparam int KEY_W    = 8;
    localparam int VALUE_W  = 16;
    localparam int CAP_W    = 7;
    localparam int BYTES_W  = 8;
    localparam int ACTION_W = 2;
    localparam int STATUS_W = 2;

    localparam logic [ACTION_W-1:0] ACT_ADD    = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_LOOKUP = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_DUMP   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd3;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } kvrt_record_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                found;
        logic [KEY_W-1:0]    out_key;
        logic [VALUE_W-1:0]  out_value;
        logic                last;
    } kvrt_result_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_LOOKUP,
        FSM_DUMP,
        FSM_RESP
    } kvrt_state_t;

endpackage

// File: design/kvrt_mem.sv
`timescale 1ns / 1ps

module kvrt_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                  aclk,
    input  logic                  wr_en,
    input  logic [AW-1:0]         wr_addr,
    input  kvrt_pkg::kvrt_record_t wr_data,
    input  logic                  rd_en,
    input  logic [AW-1:0]         rd_addr,
    output kvrt_pkg::kvrt_record_t rd_data
);
    import kvrt_pkg::*;

    kvrt_record_t mem_reg [DEPTH];
    kvrt_record_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // hold the last word read until the next read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: design/kvrt_ctrl.sv
`timescale 1ns / 1ps

module kvrt_ctrl #(
    parameter int MAX_ENTRIES = 64,
    parameter int AW          = 6,
    parameter int CW          = 7
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [kvrt_pkg::ACTION_W-1:0]      s_action,
    input  logic [kvrt_pkg::KEY_W-1:0]         s_key,
    input  logic [kvrt_pkg::VALUE_W-1:0]       s_value,
    input  logic [kvrt_pkg::CAP_W-1:0]         capacity,
    output logic                               res_valid,
    input  logic                               res_ready,
    output kvrt_pkg::kvrt_result_t             res,
    output logic [CW-1:0]                      count,
    output logic                               wr_en,
    output logic [AW-1:0]                      wr_addr,
    output kvrt_pkg::kvrt_record_t             wr_data,
    output logic                               rd_en,
    output logic [AW-1:0]                      rd_addr,
    input  kvrt_pkg::kvrt_record_t             rd_data
);
    import kvrt_pkg::*;

    kvrt_state_t  state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] issue_reg, issue_next;
    logic [CW-1:0] emit_reg, emit_next;
    logic          rd_valid_reg, rd_valid_next;
    logic [KEY_W-1:0] key_reg, key_next;
    kvrt_result_t  pend_reg, pend_next;

    logic          accept;
    logic          full;
    logic          more;
    logic          hit;
    logic          emit;
    logic          dump_last;
    logic [7:0]    count_ext;

    assign accept    = s_valid && s_ready;
    assign count_ext = 8'(count_reg);
    assign full      = (count_ext >= {1'b0, capacity}) || (count_ext >= 8'(MAX_ENTRIES));
    assign more      = issue_reg < count_reg;
    assign hit       = rd_valid_reg && (rd_data.key == key_reg);
    assign dump_last = CW'(emit_reg + 1'b1) == count_reg;

    assign count   = count_reg;
    assign wr_addr = count_reg[AW-1:0];
    assign wr_data = '{key: s_key, value: s_value};
    assign rd_addr = issue_reg[AW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= FSM_IDLE;
            count_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            rd_valid_reg <= rd_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        issue_reg <= issue_next;
        emit_reg  <= emit_next;
        key_reg   <= key_next;
        pend_reg  <= pend_next;
    end

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        issue_next    = issue_reg;
        emit_next     = emit_reg;
        rd_valid_next = 1'b0;
        key_next      = key_reg;
        pend_next     = pend_reg;
        s_ready       = 1'b0;
        wr_en         = 1'b0;
        rd_en         = 1'b0;
        res_valid     = 1'b0;
        res           = pend_reg;
        emit          = 1'b0;

        case (state_reg)
            FSM_IDLE: begin
                s_ready = 1'b1;
                if (accept) begin
                    issue_next = '0;
                    emit_next  = '0;
                    key_next   = s_key;
                    pend_next  = '{status: ST_OK, found: 1'b0, out_key: '0,
                                   out_value: '0, last: 1'b1};
                    case (s_action)
                        ACT_ADD: begin
                            if (full) begin
                                pend_next.status = ST_FULL;
                            end else begin
                                wr_en      = 1'b1;
                                count_next = CW'(count_reg + 1'b1);
                            end
                            state_next = FSM_RESP;
                        end
                        ACT_LOOKUP: begin
                            if (count_reg == '0) begin
                                pend_next.status = ST_NOT_FOUND;
                                state_next       = FSM_RESP;
                            end else begin
                                state_next = FSM_LOOKUP;
                            end
                        end
                        ACT_DUMP: begin
                            if (count_reg == '0) begin
                                pend_next.status = ST_EMPTY;
                                state_next       = FSM_RESP;
                            end else begin
                                state_next = FSM_DUMP;
                            end
                        end
                        default: begin
                            state_next = FSM_IDLE;
                        end
                    endcase
                end
            end

            FSM_LOOKUP: begin
                // one read issued per cycle, compare the word read the cycle before
                if (hit) begin
                    pend_next.status    = ST_OK;
                    pend_next.found     = 1'b1;
                    pend_next.out_key   = key_reg;
                    pend_next.out_value = rd_data.value;
                    state_next          = FSM_RESP;
                end else if (more) begin
                    rd_en         = 1'b1;
                    rd_valid_next = 1'b1;
                    issue_next    = CW'(issue_reg + 1'b1);
                end else if (rd_valid_reg) begin
                    pend_next.status = ST_NOT_FOUND;
                    state_next       = FSM_RESP;
                end
            end

            FSM_DUMP: begin
                res_valid = rd_valid_reg;
                res       = '{status: ST_OK, found: 1'b0, out_key: rd_data.key,
                              out_value: rd_data.value, last: dump_last};
                emit      = rd_valid_reg && res_ready;
                if (more && (!rd_valid_reg || emit)) begin
                    rd_en      = 1'b1;
                    issue_next = CW'(issue_reg + 1'b1);
                end
                rd_valid_next = rd_en || (rd_valid_reg && !emit);
                if (emit) begin
                    emit_next = CW'(emit_reg + 1'b1);
                    if (dump_last) begin
                        state_next = FSM_IDLE;
                    end
                end
            end

            FSM_RESP: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = FSM_IDLE;
                end
            end

            default: begin
                state_next = FSM_IDLE;
            end
        endcase
    end

endmodule

// File: design/key_value_record_table.sv
`timescale 1ns / 1ps

// Append-only table of 8-bit keys with 16-bit values, three bytes per record.
// Input word (s_valid/s_ready): action, key, value. Action add appends a
// record or reports full; lookup returns the first record with a matching
// key or not-found; dump streams every record in insertion order, last set
// on the final word, or one empty-status word when the table is empty.
// Action three is taken and dropped. Every result word carries byte_count,
// three times the stored records after the input word.
// Result words leave through an output register (m_valid/m_ready); a stall
// on m_ready holds the register and the dump stream, and an input word is
// still taken while a finished result waits there.
// Records sit in one memory with a registered read. A lookup scans one
// record per cycle through the read port; a dump gives one word per cycle
// while m_ready does not stall it. One input word is worked on at a time;
// the next is taken once the final result enters the output register.
// Capacity is written through cfg_valid/cfg_ready/cfg_data; the user must
// write it only while idle, as the block itself does not enforce it.
// Reset empties the table and sets the capacity to 64; record memory is not
// cleared, as only stored records are ever read.
module key_value_record_table #(
    parameter int MAX_ENTRIES = 64
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [kvrt_pkg::ACTION_W-1:0]   s_action,
    input  logic [kvrt_pkg::KEY_W-1:0]      s_key,
    input  logic [kvrt_pkg::VALUE_W-1:0]    s_value,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [kvrt_pkg::STATUS_W-1:0]   m_status,
    output logic                            m_found,
    output logic [kvrt_pkg::KEY_W-1:0]      m_out_key,
    output logic [kvrt_pkg::VALUE_W-1:0]    m_out_value,
    output logic [kvrt_pkg::BYTES_W-1:0]    m_byte_count,
    output logic                            m_last,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [kvrt_pkg::CAP_W-1:0]      cfg_data
);
    import kvrt_pkg::*;

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    logic [CAP_W-1:0]   cap_reg;
    logic               m_valid_reg, m_valid_next;
    kvrt_result_t       out_reg;
    logic [BYTES_W-1:0] bytes_reg;

    logic               res_valid;
    logic               res_ready;
    kvrt_result_t       res;
    logic [CW-1:0]      count;
    logic [BYTES_W-1:0] count_ext;
    logic [BYTES_W-1:0] bytes_used;
    logic               load;

    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    kvrt_record_t       wr_data;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    kvrt_record_t       rd_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= CAP_RESET;
        end else if (cfg_valid) begin
            cap_reg <= cfg_data;
        end
    end

    kvrt_mem #(
        .DEPTH (MAX_ENTRIES),
        .AW    (AW)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    kvrt_ctrl #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .AW          (AW),
        .CW          (CW)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_action  (s_action),
        .s_key     (s_key),
        .s_value   (s_value),
        .capacity  (cap_reg),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .count     (count),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    assign count_ext    = BYTES_W'(count);
    assign bytes_used   = BYTES_W'((count_ext << 1) + count_ext);
    assign res_ready    = !m_valid_reg || m_ready;
    assign load         = res_valid && res_ready;
    assign m_valid_next = load || (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            out_reg   <= res;
            bytes_reg <= bytes_used;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = out_reg.status;
    assign m_found      = out_reg.found;
    assign m_out_key    = out_reg.out_key;
    assign m_out_value  = out_reg.out_value;
    assign m_byte_count = bytes_reg;
    assign m_last       = out_reg.last;

endmodule
